// ===== sv/disjoint_interval_set_insert_defines.svh =====
// Assertion macros shared by the interval set design.
`ifndef DISJOINT_INTERVAL_SET_INSERT_DEFINES_SVH
`define DISJOINT_INTERVAL_SET_INSERT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DISI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define DISI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/disi_pkg.sv =====
`default_nettype none

package disi_pkg;

   localparam int CAPACITY_DEF   = 32;
   localparam int VALUE_BITS_DEF = 16;

   localparam int VALUE_W  = 16;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_NEW      = 3'd0,
      ST_EXTENDED = 3'd1,
      ST_MERGED   = 3'd2,
      ST_COVERED  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE,
      S_EMIT
   } state_type;

   typedef struct packed {
      status_type status;
      logic       ext_left;   // grow the end of the interval left of the value
      logic       ext_right;  // grow the start of the interval right of the value
   } decision_type;

endpackage

`default_nettype wire

// ===== sv/disi_decide.sv =====
`default_nettype none

module disi_decide import disi_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic [VALUE_BITS-1:0] value,
   input  wire logic [VALUE_BITS-1:0] left_end,
   input  wire logic [VALUE_BITS-1:0] right_start,
   input  wire logic                  has_left,
   input  wire logic                  has_right,
   input  wire logic                  full,
   output decision_type               decision
);

   logic [VALUE_BITS:0]   left_next;
   logic [VALUE_BITS-1:0] right_prev;
   logic                  covered;
   logic                  adj_left;
   logic                  adj_right;

   // one bit of headroom so an end at the top value never wraps to zero
   assign left_next  = {1'b0, left_end} + {{VALUE_BITS{1'b0}}, 1'b1};
   assign right_prev = right_start - {{(VALUE_BITS-1){1'b0}}, 1'b1};

   assign covered   = has_left && (value <= left_end);
   assign adj_left  = has_left && ({1'b0, value} == left_next);
   assign adj_right = has_right && (right_start != '0) && (value == right_prev);

   always_comb begin
      decision.ext_left  = adj_left;
      decision.ext_right = adj_right && !adj_left;
      if (covered) begin
         decision.status = ST_COVERED;
      end else if (adj_left && adj_right) begin
         decision.status = ST_MERGED;
      end else if (adj_left || adj_right) begin
         decision.status = ST_EXTENDED;
      end else if (full) begin
         decision.status = ST_FULL;
      end else begin
         decision.status = ST_NEW;
      end
   end

endmodule

`default_nettype wire

// ===== sv/disjoint_interval_set_insert.sv =====
// Channel   Ports                                   Transfer
// -------   -------------------------------------   ------------------------------
// request   start, busy, req_value                  start high while busy low
// result    rsp_valid, rsp_range_start/_end,        every cycle rsp_valid is high
//           rsp_position, rsp_last, rsp_status
//
// An add scans the table, which has one read and one write port, and stops at the first start
// above the value; it then decides, writes back and emits the whole new list, one interval
// per cycle, and returns to idle; busy stays high meanwhile. Results of one add come back
// to back.
// Reset empties the set at once; the table contents need no clearing.
// The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none
`include "disjoint_interval_set_insert_defines.svh"

module disjoint_interval_set_insert import disi_pkg::*; #(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   input  wire logic [VALUE_W-1:0]  req_value,
   output      logic                rsp_valid,
   output      logic [VALUE_W-1:0]  rsp_range_start,
   output      logic [VALUE_W-1:0]  rsp_range_end,
   output      logic [POS_W-1:0]    rsp_position,
   output      logic                rsp_last,
   output      logic [STATUS_W-1:0] rsp_status
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int VB = VALUE_BITS;

   // interval table, one start and one end per entry
   logic [VB-1:0] start_mem [CAPACITY];
   logic [VB-1:0] end_mem   [CAPACITY];
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [AW-1:0] mem_ra;
   logic [VB-1:0] mem_ws;
   logic [VB-1:0] mem_wd;
   logic [VB-1:0] rd_s_ff;
   logic [VB-1:0] rd_e_ff;

   state_type     state_ff, state_in;
   logic [VB-1:0] v_ff, v_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] chk_ff, chk_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          has_right_ff, has_right_in;
   logic [VB-1:0] left_s_ff, left_s_in;
   logic [VB-1:0] left_e_ff, left_e_in;
   logic [VB-1:0] right_s_ff, right_s_in;
   logic [VB-1:0] right_e_ff, right_e_in;
   decision_type  dec_ff, dec_in;
   decision_type  dec_now;
   logic [CW-1:0] n_new_ff, n_new_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic          p1_vld_ff, p1_vld_in;
   logic [CW-1:0] p1_k_ff, p1_k_in;
   logic [VB-1:0] prev_s_ff, prev_s_in;
   logic [VB-1:0] prev_e_ff, prev_e_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [VALUE_W-1:0]  rsp_end_ff, rsp_end_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [CW-1:0] chk_inc;
   logic [CW-1:0] iss_inc;
   logic [CW-1:0] k_inc;
   logic [VB-1:0] new_s;
   logic [VB-1:0] new_e;
   logic          accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign chk_inc = chk_ff + CW'(1);
   assign iss_inc = iss_ff + CW'(1);
   assign k_inc   = p1_k_ff + CW'(1);

   disi_decide #(
      .VALUE_BITS (VALUE_BITS)
   ) u_decide (
      .value       (v_ff),
      .left_end    (left_e_ff),
      .right_start (right_s_ff),
      .has_left    (idx_ff != '0),
      .has_right   (has_right_ff),
      .full        (count_ff == CW'(CAPACITY)),
      .decision    (dec_now)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         start_mem[mem_wa] <= mem_ws;
         end_mem[mem_wa]   <= mem_wd;
      end
      rd_s_ff <= start_mem[mem_ra];
      rd_e_ff <= end_mem[mem_ra];
   end

   // new entry at position p1_k, built from the entry read for it
   always_comb begin
      new_s = rd_s_ff;
      new_e = rd_e_ff;
      case (dec_ff.status)
         ST_NEW: begin
            if (p1_k_ff == idx_ff) begin
               new_s = v_ff;
               new_e = v_ff;
            end else if (p1_k_ff > idx_ff) begin
               new_s = prev_s_ff;
               new_e = prev_e_ff;
            end
         end
         ST_EXTENDED: begin
            if (dec_ff.ext_left && (k_inc == idx_ff)) begin
               new_e = v_ff;
            end
            if (dec_ff.ext_right && (p1_k_ff == idx_ff)) begin
               new_s = v_ff;
            end
         end
         ST_MERGED: begin
            if (k_inc == idx_ff) begin
               new_s = left_s_ff;
               new_e = right_e_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      v_in          = v_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      chk_in        = chk_ff;
      chk_vld_in    = 1'b0;
      idx_in        = idx_ff;
      has_right_in  = has_right_ff;
      left_s_in     = left_s_ff;
      left_e_in     = left_e_ff;
      right_s_in    = right_s_ff;
      right_e_in    = right_e_ff;
      dec_in        = dec_ff;
      n_new_in      = n_new_ff;
      iss_in        = iss_ff;
      p1_vld_in     = 1'b0;
      p1_k_in       = p1_k_ff;
      prev_s_in     = prev_s_ff;
      prev_e_in     = prev_e_ff;
      rsp_valid_in  = 1'b0;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_wa        = p1_k_ff[AW-1:0];
      mem_ws        = new_s;
      mem_wd        = new_e;
      mem_ra        = scan_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               v_in         = VB'(req_value);
               scan_in      = '0;
               idx_in       = '0;
               has_right_in = 1'b0;
               state_in     = S_SEARCH;
            end
         end

         S_SEARCH: begin
            // keep one read in flight per cycle
            if (scan_ff < count_ff) begin
               mem_ra     = scan_ff[AW-1:0];
               chk_vld_in = 1'b1;
               chk_in     = scan_ff;
               scan_in    = scan_ff + CW'(1);
            end
            if (count_ff == '0) begin
               chk_vld_in = 1'b0;
               state_in   = S_DECIDE;
            end else if (chk_vld_ff) begin
               if (rd_s_ff > v_ff) begin
                  idx_in       = chk_ff;
                  has_right_in = 1'b1;
                  right_s_in   = rd_s_ff;
                  right_e_in   = rd_e_ff;
                  chk_vld_in   = 1'b0;
                  state_in     = S_DECIDE;
               end else begin
                  left_s_in = rd_s_ff;
                  left_e_in = rd_e_ff;
                  idx_in    = chk_inc;
                  if (chk_inc == count_ff) begin
                     chk_vld_in = 1'b0;
                     state_in   = S_DECIDE;
                  end
               end
            end
         end

         S_DECIDE: begin
            dec_in = dec_now;
            case (dec_now.status)
               ST_NEW:    n_new_in = count_ff + CW'(1);
               ST_MERGED: n_new_in = count_ff - CW'(1);
               default:   n_new_in = count_ff;
            endcase
            count_in = n_new_in;
            iss_in   = '0;
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (iss_ff < n_new_ff) begin
               // a merge pulls every entry from the merged one on up by one
               if ((dec_ff.status == ST_MERGED) && (iss_inc >= idx_ff)) begin
                  mem_ra = iss_inc[AW-1:0];
               end else begin
                  mem_ra = iss_ff[AW-1:0];
               end
               p1_vld_in = 1'b1;
               p1_k_in   = iss_ff;
               iss_in    = iss_inc;
            end
            if (p1_vld_ff) begin
               // reads run ahead of writes, so no entry is read after its rewrite
               mem_we        = 1'b1;
               prev_s_in     = rd_s_ff;
               prev_e_in     = rd_e_ff;
               rsp_valid_in  = 1'b1;
               rsp_start_in  = VALUE_W'(new_s);
               rsp_end_in    = VALUE_W'(new_e);
               rsp_pos_in    = POS_W'(p1_k_ff);
               rsp_last_in   = (k_inc == n_new_ff);
               rsp_status_in = dec_ff.status;
               if (k_inc == n_new_ff) begin
                  p1_vld_in = 1'b0;
                  state_in  = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         p1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         p1_vld_ff    <= p1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff          <= v_in;
      scan_ff       <= scan_in;
      chk_ff        <= chk_in;
      idx_ff        <= idx_in;
      has_right_ff  <= has_right_in;
      left_s_ff     <= left_s_in;
      left_e_ff     <= left_e_in;
      right_s_ff    <= right_s_in;
      right_e_ff    <= right_e_in;
      dec_ff        <= dec_in;
      n_new_ff      <= n_new_in;
      iss_ff        <= iss_in;
      p1_k_ff       <= p1_k_in;
      prev_s_ff     <= prev_s_in;
      prev_e_ff     <= prev_e_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_start = rsp_start_ff;
   assign rsp_range_end   = rsp_end_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;

   `DISI_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count overflow")
   `DISI_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "accepted add did not raise busy")
   `DISI_ASSERT_NOW(a_last_idle, clock, reset, rsp_valid && rsp_last, !busy, "busy at last result")
   `DISI_ASSERT_NEXT(a_burst_gapless, clock, reset, rsp_valid && !rsp_last, rsp_valid, "burst gap")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import disi_pkg::*; ();

   localparam int CAP          = CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 108;
   localparam int N_SEED       = 21;

   typedef struct {
      logic [VALUE_W-1:0] lo;
      logic [VALUE_W-1:0] hi;
      logic [POS_W-1:0]   pos;
      logic               last;
      status_type         status;
   } interval_rsp_type;

   // reps > 1 adds value, value + 2, value + 4, ... (isolated single-value intervals)
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [5:0]         reps;
      logic               check;
      status_type         status;
      logic [6:0]         count;
   } seed_row_type;

   localparam seed_row_type SEED_ROWS [N_SEED] = '{
      '{16'd0,     6'd1,  1'b1, ST_NEW,      7'd1},
      '{16'd0,     6'd1,  1'b1, ST_COVERED,  7'd1},
      '{16'hFFFF,  6'd1,  1'b1, ST_NEW,      7'd2},
      '{16'hFFFF,  6'd1,  1'b1, ST_COVERED,  7'd2},
      '{16'hFFFE,  6'd1,  1'b1, ST_EXTENDED, 7'd2},
      '{16'd2,     6'd1,  1'b1, ST_NEW,      7'd3},
      '{16'd1,     6'd1,  1'b1, ST_MERGED,   7'd2},
      '{16'd3,     6'd1,  1'b1, ST_EXTENDED, 7'd2},
      '{16'hFFFC,  6'd1,  1'b1, ST_NEW,      7'd3},
      '{16'hFFFD,  6'd1,  1'b1, ST_MERGED,   7'd2},
      '{16'h5555,  6'd1,  1'b1, ST_NEW,      7'd3},
      '{16'hAAAA,  6'd1,  1'b1, ST_NEW,      7'd4},
      '{16'd1000,  6'd28, 1'b0, ST_NEW,      7'd32},
      '{16'd2000,  6'd1,  1'b1, ST_FULL,     7'd32},
      '{16'd1001,  6'd1,  1'b1, ST_MERGED,   7'd31},
      '{16'd2000,  6'd1,  1'b1, ST_NEW,      7'd32},
      '{16'd2001,  6'd1,  1'b1, ST_EXTENDED, 7'd32},
      '{16'd1999,  6'd1,  1'b1, ST_EXTENDED, 7'd32},
      '{16'd3000,  6'd1,  1'b1, ST_FULL,     7'd32},
      '{16'd1003,  6'd1,  1'b1, ST_MERGED,   7'd31},
      '{16'd4,     6'd1,  1'b1, ST_EXTENDED, 7'd31}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                busy;
   logic                rsp_valid;
   logic [VALUE_W-1:0]  rsp_range_start;
   logic [VALUE_W-1:0]  rsp_range_end;
   logic [POS_W-1:0]    rsp_position;
   logic                rsp_last;
   logic [STATUS_W-1:0] rsp_status;

   logic [VALUE_W-1:0]  set_lo [CAP];
   logic [VALUE_W-1:0]  set_hi [CAP];
   int                  set_count = 0;
   interval_rsp_type    pending_intervals [$];
   int                  err_count = 0;

   disjoint_interval_set_insert i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_range_start (rsp_range_start),
      .rsp_range_end   (rsp_range_end),
      .rsp_position    (rsp_position),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic status_type add_to_set(input logic [VALUE_W-1:0] v);
      int idx;
      int k;
      bit left_adj;
      bit right_adj;
      idx = 0;
      left_adj = 1'b0;
      right_adj = 1'b0;
      // find the first interval starting above v
      while (idx < set_count && set_lo[idx] <= v) idx++;
      if (idx > 0) begin
         if (v <= set_hi[idx-1]) return ST_COVERED;
         left_adj = (int'(v) == int'(set_hi[idx-1]) + 1);
      end
      if (idx < set_count)
         right_adj = (set_lo[idx] != '0) && (int'(v) + 1 == int'(set_lo[idx]));
      if (left_adj && right_adj) begin
         set_hi[idx-1] = set_hi[idx];
         for (k = idx; k + 1 < set_count; k++) begin
            set_lo[k] = set_lo[k+1];
            set_hi[k] = set_hi[k+1];
         end
         set_count--;
         return ST_MERGED;
      end
      if (left_adj) begin
         set_hi[idx-1] = v;
         return ST_EXTENDED;
      end
      if (right_adj) begin
         set_lo[idx] = v;
         return ST_EXTENDED;
      end
      if (set_count >= CAP) return ST_FULL;
      for (k = set_count; k > idx; k--) begin
         set_lo[k] = set_lo[k-1];
         set_hi[k] = set_hi[k-1];
      end
      set_lo[idx] = v;
      set_hi[idx] = v;
      set_count++;
      return ST_NEW;
   endfunction

   function automatic void queue_interval_list(input status_type st);
      interval_rsp_type item;
      for (int k = 0; k < set_count; k++) begin
         item = '{set_lo[k], set_hi[k], POS_W'(k), k == set_count - 1, st};
         pending_intervals = {pending_intervals, item};
      end
   endfunction

   // mostly values next to, inside or one gap away from stored intervals
   function automatic logic [VALUE_W-1:0] pick_value();
      int sel;
      int k;
      sel = $urandom_range(99);
      if (set_count == 0 || sel < 20) return VALUE_W'($urandom_range(65535));
      k = $urandom_range(set_count - 1);
      if (sel < 40) return (set_lo[k] == '0) ? '0 : set_lo[k] - 1'b1;
      if (sel < 60) return (set_hi[k] == '1) ? '1 : set_hi[k] + 1'b1;
      if (sel < 70) return VALUE_W'($urandom_range(set_hi[k], set_lo[k]));
      if (sel < 85) return set_hi[k] + VALUE_W'(2);
      return set_hi[k] + VALUE_W'($urandom_range(3, 40));
   endfunction

   task automatic apply_value(input logic [VALUE_W-1:0] v, output status_type st);
      start <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy !== 1'b0);
      st = add_to_set(v);
      queue_interval_list(st);
   endtask

   task automatic idle_gap(input int pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 80)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      interval_rsp_type exp_r;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_intervals.size() == 0) begin
            $error("unexpected transfer: range_start %0d range_end %0d",
                   rsp_range_start, rsp_range_end);
            err_count++;
         end else begin
            exp_r = pending_intervals.pop_front();
            if (rsp_range_start !== exp_r.lo) begin
               $error("range_start expected %0d actual %0d", exp_r.lo, rsp_range_start);
               err_count++;
            end
            if (rsp_range_end !== exp_r.hi) begin
               $error("range_end expected %0d actual %0d", exp_r.hi, rsp_range_end);
               err_count++;
            end
            if (rsp_position !== exp_r.pos) begin
               $error("position expected %0d actual %0d", exp_r.pos, rsp_position);
               err_count++;
            end
            if (rsp_last !== exp_r.last) begin
               $error("last expected %0d actual %0d", exp_r.last, rsp_last);
               err_count++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status expected %0d actual %0d", exp_r.status, rsp_status);
               err_count++;
            end
         end
      end
   end

   initial begin
      int idle_pct [4] = '{0, 65, 0, 32};
      status_type st;
      seed_row_type row;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (SEED_ROWS[r]) begin
         row = SEED_ROWS[r];
         for (int i = 0; i < row.reps; i++)
            apply_value(row.value + VALUE_W'(2 * i), st);
         if (row.check) begin
            if (st !== row.status) begin
               $error("status expected %0d actual %0d", row.status, st);
               err_count++;
            end
            if (set_count != row.count) begin
               $error("interval count expected %0d actual %0d", row.count, set_count);
               err_count++;
            end
         end
      end

      foreach (idle_pct[p])
         for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_gap(idle_pct[p]);
            apply_value(pick_value(), st);
         end
      start <= 1'b0;

      while (pending_intervals.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (err_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
